// ===== hw/rtl/rppc_pkg.sv =====
// ----------------------------------------------------------------------------
// rppc_pkg
// Types, constants and helpers shared by the RGB pixel point converter.
// ----------------------------------------------------------------------------
package rppc_pkg;

    // samples and register values are saturated to this many bits before use
    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // configuration port
    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE           = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_SELECT = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_MAX      = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GREY_MAX       = 4'd3;

    localparam logic [15:0] INPUT_MAX_RESET = 16'd255;
    localparam logic [15:0] GREY_MAX_RESET  = 16'd255;

    typedef enum logic [2:0] {
        MODE_BITMAP  = 3'd0,
        MODE_GREY    = 3'd1,
        MODE_SEPIA   = 3'd2,
        MODE_ISOLATE = 3'd3,
        MODE_REMOVE  = 3'd4
    } mode_t;

    // sepia matrix in thousandths, row = output channel, column = input channel
    localparam logic [9:0] SEPIA_COEF [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

    // x / 1000 = (x >> 3) / 125, the latter as a reciprocal multiply that is
    // exact for any 24 bit operand
    localparam int          SEPIA_SHIFT = 3;
    localparam logic [24:0] RECIP_125   = 25'd17179870;
    localparam int          RECIP_SHIFT = 31;

    // greyscale divider: 16 quotient bits spread over the pipeline
    localparam int QUOT_BITS          = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = QUOT_BITS / DIV_BITS_PER_STAGE;

    typedef struct packed {
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] level_out;
    } pixel_out_t;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  channel_select;
        logic [15:0] input_max;
        logic [15:0] grey_max;
    } cfg_t;

    // results that ride alongside the divider
    typedef struct packed {
        mode_t            mode;
        logic [15:0]      mx;
        logic [15:0]      gm;
        logic             grey_sat;
        logic             bitmap_bit;
        logic [2:0][15:0] pass_rgb;
        logic [2:0][26:0] sepia_sum;
    } side_t;

    typedef struct packed {
        logic [17:0] rem;
        logic [15:0] low;
        logic [15:0] quot;
        logic [17:0] divisor;
    } div_t;

    typedef struct packed {
        side_t side;
        div_t  div;
    } stage_t;

    function automatic logic [15:0] sat_sample(input logic [15:0] v);
        return (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

endpackage

// ===== hw/rtl/rppc_prep.sv =====
// ----------------------------------------------------------------------------
// rppc_prep
// First two pipeline stages: saturation, channel sum, sepia products, then
// sepia sums, greyscale product, bitmap compare and channel pass selection.
// ----------------------------------------------------------------------------
module rppc_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  rppc_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  rppc_pkg::pixel_in_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rppc_pkg::stage_t    m_stage
);

    logic v1_reg;
    logic v2_reg;
    logic ready1;
    logic ready2;

    rppc_pkg::mode_t mode1_reg;
    logic [1:0]      chsel1_reg;
    logic [15:0]     c1_reg [3];
    logic [15:0]     mx1_reg;
    logic [15:0]     gm1_reg;
    logic [17:0]     sum1_reg;
    logic [17:0]     mx3_1_reg;
    logic [25:0]     prod1_reg [3][3];

    logic [15:0] c_next [3];
    logic [15:0] mx_next;
    logic [15:0] gm_next;
    logic [25:0] prod_next [3][3];

    rppc_pkg::stage_t stage2_reg;
    rppc_pkg::stage_t stage2_next;

    assign ready2  = !v2_reg || m_ready;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;
    assign m_valid = v2_reg;
    assign m_stage = stage2_reg;

    always_comb begin
        c_next[0] = rppc_pkg::sat_sample(s_data.red_in);
        c_next[1] = rppc_pkg::sat_sample(s_data.green_in);
        c_next[2] = rppc_pkg::sat_sample(s_data.blue_in);
        mx_next   = rppc_pkg::sat_sample(cfg.input_max);
        if (mx_next == 16'd0) begin
            mx_next = 16'd1;
        end
        gm_next = rppc_pkg::sat_sample(cfg.grey_max);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = 26'(rppc_pkg::SEPIA_COEF[i][j]) * 26'(c_next[j]);
            end
        end
    end

    always_comb begin
        logic [33:0] gprod;
        gprod = 34'(sum1_reg) * 34'(gm1_reg);
        stage2_next.side.mode       = mode1_reg;
        stage2_next.side.mx         = mx1_reg;
        stage2_next.side.gm         = gm1_reg;
        // quotient reaches grey_max exactly when the sum reaches 3*max
        stage2_next.side.grey_sat   = (sum1_reg >= mx3_1_reg);
        stage2_next.side.bitmap_bit = ({sum1_reg, 1'b0} < {1'b0, mx3_1_reg});
        for (int i = 0; i < 3; i++) begin
            stage2_next.side.sepia_sum[i] = 27'(prod1_reg[i][0]) + 27'(prod1_reg[i][1])
                                          + 27'(prod1_reg[i][2]);
            if (mode1_reg == rppc_pkg::MODE_ISOLATE) begin
                stage2_next.side.pass_rgb[i] = (chsel1_reg == 2'(i)) ? c1_reg[i] : 16'd0;
            end else if (mode1_reg == rppc_pkg::MODE_REMOVE) begin
                stage2_next.side.pass_rgb[i] = (chsel1_reg == 2'(i)) ? 16'd0 : c1_reg[i];
            end else begin
                stage2_next.side.pass_rgb[i] = 16'd0;
            end
        end
        stage2_next.div.rem     = gprod[33:16];
        stage2_next.div.low     = gprod[15:0];
        stage2_next.div.quot    = 16'd0;
        stage2_next.div.divisor = mx3_1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && s_valid) begin
            mode1_reg  <= cfg.mode;
            chsel1_reg <= cfg.channel_select;
            c1_reg     <= c_next;
            mx1_reg    <= mx_next;
            gm1_reg    <= gm_next;
            sum1_reg   <= 18'(c_next[0]) + 18'(c_next[1]) + 18'(c_next[2]);
            mx3_1_reg  <= {1'b0, mx_next, 1'b0} + 18'(mx_next);
            prod1_reg  <= prod_next;
        end
        if (ready2 && v1_reg) begin
            stage2_reg <= stage2_next;
        end
    end

endmodule

// ===== hw/rtl/rppc_div_step.sv =====
// ----------------------------------------------------------------------------
// rppc_div_step
// One stage of the greyscale restoring divider, a few quotient bits per stage,
// with the side results carried along unchanged.
// ----------------------------------------------------------------------------
module rppc_div_step (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rppc_pkg::stage_t s_stage,
    output logic             m_valid,
    input  logic             m_ready,
    output rppc_pkg::stage_t m_stage
);

    logic             valid_reg;
    rppc_pkg::stage_t stage_reg;
    rppc_pkg::stage_t stage_next;

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_stage = stage_reg;

    always_comb begin
        logic [18:0] trial;
        stage_next = s_stage;
        for (int k = 0; k < rppc_pkg::DIV_BITS_PER_STAGE; k++) begin
            trial = {stage_next.div.rem, stage_next.div.low[15]};
            stage_next.div.low = {stage_next.div.low[14:0], 1'b0};
            if (trial >= {1'b0, stage_next.div.divisor}) begin
                trial = trial - {1'b0, stage_next.div.divisor};
                stage_next.div.quot = {stage_next.div.quot[14:0], 1'b1};
            end else begin
                stage_next.div.quot = {stage_next.div.quot[14:0], 1'b0};
            end
            // remainder stays below the divisor unless the level saturates
            stage_next.div.rem = trial[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ===== hw/rtl/rppc_finish.sv =====
// ----------------------------------------------------------------------------
// rppc_finish
// Last two stages: sepia divide by 1000 through a reciprocal multiply and greyscale
// saturation, then clamping and mode selection into the output register.
// ----------------------------------------------------------------------------
module rppc_finish (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rppc_pkg::stage_t     s_stage,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rppc_pkg::pixel_out_t m_data
);

    logic v1_reg;
    logic v2_reg;
    logic ready1;
    logic ready2;

    rppc_pkg::mode_t  mode1_reg;
    logic [15:0]      mx1_reg;
    logic [15:0]      grey1_reg;
    logic             bitmap1_reg;
    logic [2:0][15:0] pass1_reg;
    logic [17:0]      sepia_q1_reg [3];

    logic [17:0]          sepia_q_next [3];
    logic [15:0]          sepia_clamp [3];
    rppc_pkg::pixel_out_t out_next;
    rppc_pkg::pixel_out_t out_reg;

    assign ready2  = !v2_reg || m_ready;
    assign ready1  = !v1_reg || ready2;
    assign s_ready = ready1;
    assign m_valid = v2_reg;
    assign m_data  = out_reg;

    always_comb begin
        logic [48:0] prod;
        for (int i = 0; i < 3; i++) begin
            prod = 49'(s_stage.side.sepia_sum[i][26:rppc_pkg::SEPIA_SHIFT])
                 * 49'(rppc_pkg::RECIP_125);
            sepia_q_next[i] = prod[48:rppc_pkg::RECIP_SHIFT];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sepia_clamp[i] = (sepia_q1_reg[i] > {2'b00, mx1_reg}) ? mx1_reg
                                                                  : sepia_q1_reg[i][15:0];
        end
        out_next = '0;
        unique case (mode1_reg)
            rppc_pkg::MODE_BITMAP: begin
                out_next.level_out = {15'd0, bitmap1_reg};
            end
            rppc_pkg::MODE_GREY: begin
                out_next.level_out = grey1_reg;
            end
            rppc_pkg::MODE_SEPIA: begin
                out_next.red_out   = sepia_clamp[0];
                out_next.green_out = sepia_clamp[1];
                out_next.blue_out  = sepia_clamp[2];
            end
            rppc_pkg::MODE_ISOLATE, rppc_pkg::MODE_REMOVE: begin
                out_next.red_out   = pass1_reg[0];
                out_next.green_out = pass1_reg[1];
                out_next.blue_out  = pass1_reg[2];
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && s_valid) begin
            mode1_reg    <= s_stage.side.mode;
            mx1_reg      <= s_stage.side.mx;
            grey1_reg    <= s_stage.side.grey_sat ? s_stage.side.gm : s_stage.div.quot;
            bitmap1_reg  <= s_stage.side.bitmap_bit;
            pass1_reg    <= s_stage.side.pass_rgb;
            sepia_q1_reg <= sepia_q_next;
        end
        if (ready2 && v1_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hw/rtl/rgb_pixel_point_converter_top.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_point_converter_top
// Per-pixel RGB converter: bitmap threshold, greyscale, sepia, channel isolate
// and channel remove, selected by configuration registers.
// ----------------------------------------------------------------------------
//  channel   direction  ports                              payload
//  s_        in         s_valid s_ready s_data             pixel_in_t
//  m_        out        m_valid m_ready m_data             pixel_out_t
//  cfg_      in         cfg_valid cfg_ready cfg_index      cfg_wdata (16 bit)
//
//  one pixel per cycle sustained while m_ready is high; 2 prep stages, 8 divider
//  stages of 2 quotient bits each for the greyscale level, 2 finish stages
//  every stage has its own valid bit and holds under stall, so bubbles close up
//  and s_ready falls only when every stage is full and m_ready is low
//  synchronous active-low reset clears the valids and loads the register
//  defaults; configuration transfers are always taken (cfg_ready high)
// ----------------------------------------------------------------------------
module rgb_pixel_point_converter_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rppc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [15:0]                            cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rppc_pkg::pixel_in_t                    s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rppc_pkg::pixel_out_t                   m_data
);

    rppc_pkg::mode_t mode_reg;
    logic [1:0]      chsel_reg;
    logic [15:0]     input_max_reg;
    logic [15:0]     grey_max_reg;
    rppc_pkg::cfg_t  cfg;

    logic [rppc_pkg::DIV_STAGES:0] chain_valid;
    logic [rppc_pkg::DIV_STAGES:0] chain_ready;
    rppc_pkg::stage_t              chain_stage [rppc_pkg::DIV_STAGES+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= rppc_pkg::MODE_BITMAP;
            chsel_reg     <= 2'd0;
            input_max_reg <= rppc_pkg::INPUT_MAX_RESET;
            grey_max_reg  <= rppc_pkg::GREY_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rppc_pkg::REG_MODE:           mode_reg      <= rppc_pkg::mode_t'(cfg_wdata[2:0]);
                rppc_pkg::REG_CHANNEL_SELECT: chsel_reg     <= cfg_wdata[1:0];
                rppc_pkg::REG_INPUT_MAX:      input_max_reg <= cfg_wdata;
                rppc_pkg::REG_GREY_MAX:       grey_max_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = '{
        mode:           mode_reg,
        channel_select: chsel_reg,
        input_max:      input_max_reg,
        grey_max:       grey_max_reg
    };

    rppc_prep u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (chain_valid[0]),
        .m_ready (chain_ready[0]),
        .m_stage (chain_stage[0])
    );

    for (genvar g = 0; g < rppc_pkg::DIV_STAGES; g++) begin : g_div
        rppc_div_step u_div_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (chain_valid[g]),
            .s_ready (chain_ready[g]),
            .s_stage (chain_stage[g]),
            .m_valid (chain_valid[g+1]),
            .m_ready (chain_ready[g+1]),
            .m_stage (chain_stage[g+1])
        );
    end

    rppc_finish u_finish (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (chain_valid[rppc_pkg::DIV_STAGES]),
        .s_ready (chain_ready[rppc_pkg::DIV_STAGES]),
        .s_stage (chain_stage[rppc_pkg::DIV_STAGES]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // input stalls only when the whole pipeline is full behind a stalled output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&chain_valid)))
        else $error("input stalled while a pipeline stage is empty");

    // the finish stages back-pressure only while the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !chain_ready[rppc_pkg::DIV_STAGES] |-> (m_valid && !m_ready))
        else $error("finish stages stalled without output back-pressure");

    assert property (@(posedge aclk) !aresetn |=> (!m_valid && (chain_valid == '0)))
        else $error("valid bits not cleared by reset");

endmodule
